// ===== rtl/smp_pkg.sv =====
// ----------------------------------------------------------------------------
// smp_pkg
// shared constants and controller/datapath interface types for the storage
// mount placement unit
// ----------------------------------------------------------------------------
package smp_pkg;

	localparam int MAX_MOUNTS_DEF = 8;
	localparam int SIZE_BITS_DEF  = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREE_RATIO    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILES_PER_DIR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBDIR_COUNT  = 2'd3;

	localparam logic [3:0]  MOUNT_COUNT_RST   = 4'd1;
	localparam logic [16:0] FREE_RATIO_RST    = 17'd0;
	localparam logic [15:0] FILES_PER_DIR_RST = 16'd1;
	localparam logic [8:0]  SUBDIR_COUNT_RST  = 9'd256;

	localparam logic [16:0] Q16_ONE    = 17'h10000;
	localparam logic [8:0]  SUBDIR_MAX = 9'd256;

	typedef struct packed {
		logic capture;
		logic size_wr;
		logic div_step;
		logic size_rd;
		logic rd_scan;
		logic mul;
		logic scan_clr;
		logic scan_next;
		logic take_scan;
		logic dir_rd;
		logic dir_wr;
		logic res_clr;
		logic res_err;
		logic load_out;
	} smp_cmd_t;

	typedef struct packed {
		logic is_place;
		logic div_last;
		logic too_full;
		logic scan_skip;
		logic scan_end;
	} smp_sts_t;

endpackage

// ===== rtl/smp_ctrl.sv =====
// ----------------------------------------------------------------------------
// smp_ctrl
// sequencer for the placement unit: handshakes, remainder steps, mount scan,
// directory update and output register load
// ----------------------------------------------------------------------------
module smp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  smp_pkg::smp_sts_t sts,
	output smp_pkg::smp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_DIV,
		S_RD,
		S_MUL,
		S_CMP,
		S_SCAN,
		S_DRD,
		S_DUPD,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   scanning_q;
	logic   scanning_d;
	logic   out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		scanning_d = scanning_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.is_place) begin
					state_d = S_DIV;
				end else begin
					cmd.size_wr = 1'b1;
					cmd.res_clr = 1'b1;
					state_d     = S_OUT;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					scanning_d = 1'b0;
					state_d    = S_RD;
				end
			end
			S_RD: begin
				cmd.size_rd = 1'b1;
				cmd.rd_scan = scanning_q;
				state_d     = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (!sts.too_full) begin
					cmd.take_scan = scanning_q;
					state_d       = S_DRD;
				end else if (!scanning_q) begin
					cmd.scan_clr = 1'b1;
					scanning_d   = 1'b1;
					state_d      = S_SCAN;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					cmd.res_clr = 1'b1;
					cmd.res_err = 1'b1;
					state_d     = S_OUT;
				end else if (sts.scan_skip) begin
					cmd.scan_next = 1'b1;
				end else begin
					state_d = S_RD;
				end
			end
			S_DRD: begin
				cmd.dir_rd = 1'b1;
				state_d    = S_DUPD;
			end
			S_DUPD: begin
				cmd.dir_wr = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scanning_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			scanning_q <= scanning_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("output register loaded while holding an untaken transaction");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_DISP))
		else $error("accepted transaction not dispatched");

	a_div_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_last) |=> (state_q == S_RD && !scanning_q))
		else $error("remainder done without reading the picked mount");

	a_scan_end_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && sts.scan_end) |=> (state_q == S_OUT))
		else $error("scan ran past the last mount");

endmodule

// ===== rtl/smp_dp.sv =====
// ----------------------------------------------------------------------------
// smp_dp
// datapath: configuration registers, mount size and directory tables,
// serial remainder unit, fullness multiply and compare, result registers
// ----------------------------------------------------------------------------
module smp_dp #(
	parameter int MAX_MOUNTS = smp_pkg::MAX_MOUNTS_DEF,
	parameter int SIZE_BITS  = smp_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smp_pkg::smp_cmd_t               cmd,
	output smp_pkg::smp_sts_t               sts,
	input  logic                            cfg_valid,
	input  logic [smp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [smp_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [0:0]                      s_tuser,
	output logic [smp_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [0:0]                      m_tuser
);

	localparam int IW  = (MAX_MOUNTS > 1) ? $clog2(MAX_MOUNTS) : 1;
	localparam int NW0 = $clog2(MAX_MOUNTS + 1);
	localparam int NW  = (NW0 > 4) ? NW0 : 4;
	localparam int PW  = SIZE_BITS + 17;
	localparam int FW  = SIZE_BITS + 16;

	// configuration
	logic [3:0]  mount_count_q;
	logic [16:0] free_ratio_q;
	logic [15:0] files_per_dir_q;
	logic [8:0]  subdir_count_q;

	// captured transaction
	logic        mode_q;
	logic [2:0]  sel_q;
	logic [31:0] total_in_q;
	logic [31:0] free_in_q;

	// remainder unit and scan
	logic [15:0]   dividend_q;
	logic [NW-1:0] pick_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] scan_q;
	logic [3:0]    bit_cnt_q;
	logic [NW-1:0] n_act;
	logic [NW-1:0] mc_ext;
	logic [NW:0]   div_t;
	logic [NW:0]   div_n;
	logic [NW-1:0] rem_d;

	// tables
	logic [2*SIZE_BITS-1:0] size_mem [MAX_MOUNTS];
	logic [31:0]            dir_mem  [MAX_MOUNTS];
	logic [MAX_MOUNTS-1:0]  size_vld_q;
	logic [MAX_MOUNTS-1:0]  dir_vld_q;
	logic [2*SIZE_BITS-1:0] size_rd_q;
	logic                   size_rd_vld_q;
	logic [31:0]            dir_rd_q;
	logic                   dir_rd_vld_q;
	logic [IW-1:0]          rd_idx;
	logic [IW-1:0]          sel_idx;
	logic [IW-1:0]          pick_idx;
	logic                   sel_ok;

	// fullness test
	logic [SIZE_BITS-1:0] total_m;
	logic [SIZE_BITS-1:0] free_m;
	logic [16:0]          ratio_c;
	logic [PW-1:0]        product_q;
	logic [FW-1:0]        free_sh_q;

	// directory step
	logic [31:0] dir_cur;
	logic [16:0] cnt_inc;
	logic [8:0]  subs;
	logic [8:0]  lower_n;
	logic [8:0]  upper_n;
	logic [15:0] cnt_n;
	logic        adv_n;

	// result and output registers
	logic       res_status_q;
	logic [2:0] res_mount_q;
	logic [7:0] res_upper_q;
	logic [7:0] res_lower_q;
	logic       res_adv_q;
	logic       out_status_q;
	logic [2:0] out_mount_q;
	logic [7:0] out_upper_q;
	logic [7:0] out_lower_q;
	logic       out_adv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_count_q   <= smp_pkg::MOUNT_COUNT_RST;
			free_ratio_q    <= smp_pkg::FREE_RATIO_RST;
			files_per_dir_q <= smp_pkg::FILES_PER_DIR_RST;
			subdir_count_q  <= smp_pkg::SUBDIR_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				smp_pkg::CFG_MOUNT_COUNT:   mount_count_q   <= cfg_data[3:0];
				smp_pkg::CFG_FREE_RATIO:    free_ratio_q    <= cfg_data[16:0];
				smp_pkg::CFG_FILES_PER_DIR: files_per_dir_q <= cfg_data[15:0];
				smp_pkg::CFG_SUBDIR_COUNT:  subdir_count_q  <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// active mount count, clamped to one and to the table depth
	always_comb begin
		mc_ext = NW'(mount_count_q);
		if (mc_ext == '0) begin
			n_act = NW'(1);
		end else if (mc_ext > NW'(MAX_MOUNTS)) begin
			n_act = NW'(MAX_MOUNTS);
		end else begin
			n_act = mc_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= s_tuser[0];
			sel_q      <= s_tdata[18:16];
			total_in_q <= s_tdata[50:19];
			free_in_q  <= s_tdata[82:51];
		end
	end

	// restoring remainder, one dividend bit per step
	assign div_n = {1'b0, n_q};
	assign div_t = {pick_q, dividend_q[15]};
	assign rem_d = (div_t >= div_n) ? NW'(div_t - div_n) : div_t[NW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dividend_q <= '0;
			pick_q     <= '0;
			n_q        <= NW'(1);
			scan_q     <= '0;
			bit_cnt_q  <= '0;
		end else begin
			if (cmd.capture) begin
				dividend_q <= s_tdata[15:0];
				pick_q     <= '0;
				n_q        <= n_act;
				bit_cnt_q  <= '0;
			end else if (cmd.div_step) begin
				dividend_q <= {dividend_q[14:0], 1'b0};
				pick_q     <= rem_d;
				bit_cnt_q  <= bit_cnt_q + 4'd1;
			end else if (cmd.take_scan) begin
				pick_q <= scan_q;
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.scan_next) begin
				scan_q <= scan_q + NW'(1);
			end
		end
	end

	assign sel_ok   = (32'(sel_q) < MAX_MOUNTS);
	assign sel_idx  = IW'(sel_q);
	assign pick_idx = pick_q[IW-1:0];
	assign rd_idx   = cmd.rd_scan ? scan_q[IW-1:0] : pick_idx;

	always_ff @(posedge clk) begin
		if (cmd.size_wr && sel_ok) begin
			size_mem[sel_idx] <= {SIZE_BITS'(free_in_q), SIZE_BITS'(total_in_q)};
		end
		if (cmd.size_rd) begin
			size_rd_q <= size_mem[rd_idx];
		end
		if (cmd.dir_wr) begin
			dir_mem[pick_idx] <= {cnt_n, upper_n[7:0], lower_n[7:0]};
		end
		if (cmd.dir_rd) begin
			dir_rd_q <= dir_mem[pick_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_vld_q    <= '0;
			dir_vld_q     <= '0;
			size_rd_vld_q <= 1'b0;
			dir_rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.size_wr && sel_ok) begin
				size_vld_q[sel_idx] <= 1'b1;
			end
			if (cmd.dir_wr) begin
				dir_vld_q[pick_idx] <= 1'b1;
			end
			if (cmd.size_rd) begin
				size_rd_vld_q <= size_vld_q[rd_idx];
			end
			if (cmd.dir_rd) begin
				dir_rd_vld_q <= dir_vld_q[pick_idx];
			end
		end
	end

	// too full when free * 2^16 < ratio * total
	assign total_m = size_rd_vld_q ? size_rd_q[SIZE_BITS-1:0] : '0;
	assign free_m  = size_rd_vld_q ? size_rd_q[2*SIZE_BITS-1:SIZE_BITS] : '0;
	assign ratio_c = (free_ratio_q > smp_pkg::Q16_ONE) ? smp_pkg::Q16_ONE : free_ratio_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			product_q <= ratio_c * total_m;
			free_sh_q <= {free_m, 16'h0000};
		end
	end

	// directory position step
	always_comb begin
		dir_cur = dir_rd_vld_q ? dir_rd_q : '0;
		cnt_inc = {1'b0, dir_cur[31:16]} + 17'd1;
		subs    = (subdir_count_q > smp_pkg::SUBDIR_MAX) ? smp_pkg::SUBDIR_MAX : subdir_count_q;
		lower_n = {1'b0, dir_cur[7:0]};
		upper_n = {1'b0, dir_cur[15:8]};
		cnt_n   = cnt_inc[15:0];
		adv_n   = 1'b0;
		if (cnt_inc >= {1'b0, files_per_dir_q}) begin
			cnt_n   = '0;
			adv_n   = 1'b1;
			lower_n = lower_n + 9'd1;
			if (lower_n >= subs) begin
				upper_n = upper_n + 9'd1;
				if (upper_n >= subs) begin
					upper_n = '0;
				end
				lower_n = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_clr) begin
			res_status_q <= cmd.res_err;
			res_mount_q  <= '0;
			res_upper_q  <= '0;
			res_lower_q  <= '0;
			res_adv_q    <= 1'b0;
		end else if (cmd.dir_wr) begin
			res_status_q <= 1'b0;
			res_mount_q  <= 3'(pick_q);
			res_upper_q  <= upper_n[7:0];
			res_lower_q  <= lower_n[7:0];
			res_adv_q    <= adv_n;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_mount_q  <= res_mount_q;
			out_upper_q  <= res_upper_q;
			out_lower_q  <= res_lower_q;
			out_adv_q    <= res_adv_q;
		end
	end

	assign m_tdata = {4'h0, out_adv_q, out_lower_q, out_upper_q, out_mount_q};
	assign m_tuser = out_status_q;

	assign sts.is_place  = mode_q;
	assign sts.div_last  = (bit_cnt_q == 4'd15);
	assign sts.too_full  = (PW'(free_sh_q) < product_q);
	assign sts.scan_skip = (scan_q == pick_q);
	assign sts.scan_end  = (scan_q == n_q);

endmodule

// ===== rtl/storage_mount_placement_unit.sv =====
// ----------------------------------------------------------------------------
// storage_mount_placement_unit
// an update writes the size table and loads the result; a placement runs the
// 16-step serial remainder unit to hash the connection id to a mount, reads
// that mount from the size table and, if it is too full, scans the further
// mounts in order, stepping over the hashed entry; an all-full error is
// reported once the scan passes the last mount; one transaction at a time,
// and output stalls hold the unit in its output state;
// reset clears configuration to its defaults and all table valid bits
module storage_mount_placement_unit #(
	parameter int MAX_MOUNTS = smp_pkg::MAX_MOUNTS_DEF,
	parameter int SIZE_BITS  = smp_pkg::SIZE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [smp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// conn_id[15:0], mount_sel[18:16], total_mb[50:19], free_mb[82:51]
	input  logic [smp_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode[0]
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// chosen_mount[2:0], upper_dir[10:3], lower_dir[18:11], dir_advanced[19]
	output logic [smp_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[0]
	output logic [0:0]                     m_tuser
);

	smp_pkg::smp_cmd_t cmd;
	smp_pkg::smp_sts_t sts;

	assign cfg_ready = 1'b1;

	smp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smp_dp #(
		.MAX_MOUNTS (MAX_MOUNTS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the storage mount placement unit. A directed table
// covers field extremes, register extremes, the overfull fallback scan, the
// all-mounts-full error and directory rollover. Random size updates around
// the fill threshold and random placements follow, under several register
// settings and idle patterns. Results are checked against a directed row's
// expected value or a local model of the mount table and directory counters.
// ----------------------------------------------------------------------------
module tb_top;
	import smp_pkg::*;

	localparam int  NUM_MOUNTS  = MAX_MOUNTS_DEF;
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_PLACE  = 1'b1;
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_FULL     = 1'b1;
	localparam int  RAND_ITEMS  = 100;
	localparam int  SETTLE_CYC  = 100;

	typedef struct packed {
		logic        mode;
		logic [15:0] conn_id;
		logic [2:0]  mount_sel;
		logic [31:0] total_mb;
		logic [31:0] free_mb;
	} place_req_t;

	typedef struct packed {
		logic       status;
		logic [2:0] chosen_mount;
		logic [7:0] upper_dir;
		logic [7:0] lower_dir;
		logic       dir_advanced;
	} place_res_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		place_req_t            req;
		bit                    chk;
		place_res_t            want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;

	// mount table and directory position model
	logic [3:0]  cfg_mounts = MOUNT_COUNT_RST;
	logic [16:0] cfg_ratio  = FREE_RATIO_RST;
	logic [15:0] cfg_fpd    = FILES_PER_DIR_RST;
	logic [8:0]  cfg_subs   = SUBDIR_COUNT_RST;
	logic [31:0] mnt_total [NUM_MOUNTS];
	logic [31:0] mnt_free  [NUM_MOUNTS];
	logic [7:0]  dir_up    [NUM_MOUNTS];
	logic [7:0]  dir_lo    [NUM_MOUNTS];
	logic [15:0] file_cnt  [NUM_MOUNTS];

	place_res_t  result_q [$];
	stim_row_t   stim_tab [$];
	int unsigned fail_cnt = 0;
	int unsigned snd_idle = 11;
	int unsigned rcv_idle = 71;

	int unsigned ph_mounts [6] = '{8, 3, 5, 0, 15, 6};
	int unsigned ph_ratio  [6] = '{32768, 65536, 131071, 49152, 0, 60000};
	int unsigned ph_fpd    [6] = '{2, 1, 4, 0, 65535, 3};
	int unsigned ph_subs   [6] = '{3, 256, 2, 1, 511, 4};

	storage_mount_placement_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic mount_overfull(int unsigned m);
		logic [63:0] eff;
		eff = (cfg_ratio > Q16_ONE) ? 64'(Q16_ONE) : 64'(cfg_ratio);
		return (64'(mnt_free[m]) << 16) < (eff * 64'(mnt_total[m]));
	endfunction

	function automatic place_res_t predict_placement(place_req_t r);
		place_res_t  res;
		int unsigned n, pick, subs, cnt, lo, up;
		bit          found;
		res = '0;
		if (r.mode == MODE_UPDATE) begin
			mnt_total[r.mount_sel] = r.total_mb;
			mnt_free[r.mount_sel]  = r.free_mb;
			return res;
		end
		n = (cfg_mounts == 0) ? 1 : (cfg_mounts > NUM_MOUNTS) ? NUM_MOUNTS : cfg_mounts;
		pick = r.conn_id % n;
		found = !mount_overfull(pick);
		if (!found) begin
			for (int i = 0; i < n; i++) begin
				if (i != pick && !mount_overfull(i)) begin
					pick = i;
					found = 1'b1;
					break;
				end
			end
		end
		if (!found) begin
			res.status = ST_FULL;
			return res;
		end
		subs = (cfg_subs > SUBDIR_MAX) ? SUBDIR_MAX : cfg_subs;
		cnt = file_cnt[pick] + 1;
		lo = dir_lo[pick];
		up = dir_up[pick];
		if (cnt >= cfg_fpd) begin
			file_cnt[pick] = '0;
			lo++;
			if (lo >= subs) begin
				up++;
				if (up >= subs)
					up = 0;
				lo = 0;
			end
			res.dir_advanced = 1'b1;
		end else begin
			file_cnt[pick] = 16'(cnt);
		end
		dir_lo[pick] = 8'(lo);
		dir_up[pick] = 8'(up);
		res.status = ST_OK;
		res.chosen_mount = 3'(pick);
		res.upper_dir = dir_up[pick];
		res.lower_dir = dir_lo[pick];
		return res;
	endfunction

	function automatic place_req_t mk_req(logic mode, logic [15:0] conn, logic [2:0] sel,
			logic [31:0] total, logic [31:0] free);
		return {mode, conn, sel, total, free};
	endfunction

	function automatic void t_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		stim_tab.push_back('{1'b1, idx, CFG_DATA_W'(val), '0, 1'b0, '0});
	endfunction

	function automatic void t_item(place_req_t r, bit chk, place_res_t want);
		stim_tab.push_back('{1'b0, '0, '0, r, chk, want});
	endfunction

	// update sizes mostly cluster at the current fill threshold so both sides are hit
	function automatic place_req_t rand_item();
		place_req_t  r;
		logic [63:0] eff, thr;
		int unsigned shape;
		r.conn_id = 16'($urandom);
		r.mount_sel = 3'($urandom_range(NUM_MOUNTS - 1));
		r.total_mb = $urandom;
		r.free_mb = $urandom;
		if ($urandom_range(99) < 65) begin
			r.mode = MODE_PLACE;
			return r;
		end
		r.mode = MODE_UPDATE;
		shape = $urandom_range(9);
		if (shape == 0) begin
			r.total_mb = '0;
		end else if (shape == 1) begin
			r.total_mb = '1;
		end else if (shape >= 4) begin
			if ($urandom_range(1))
				r.total_mb = $urandom_range(1, 5000);
			eff = (cfg_ratio > Q16_ONE) ? 64'(Q16_ONE) : 64'(cfg_ratio);
			thr = (eff * 64'(r.total_mb)) >> 16;
			r.free_mb = 32'(thr + $urandom_range(2) - 1);
		end
		return r;
	endfunction

	function automatic void cmp_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
		end
	endfunction

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rcv_idle);

	always @(negedge clk) begin : result_check
		place_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser[0], m_tdata[2:0], m_tdata[10:3], m_tdata[18:11], m_tdata[19]};
			if (result_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: unexpected result, expected none, actual %h", $realtime, got);
			end else begin
				want = result_q.pop_front();
				cmp_field("status", want.status, got.status);
				cmp_field("chosen_mount", want.chosen_mount, got.chosen_mount);
				cmp_field("upper_dir", want.upper_dir, got.upper_dir);
				cmp_field("lower_dir", want.lower_dir, got.lower_dir);
				cmp_field("dir_advanced", want.dir_advanced, got.dir_advanced);
			end
		end
	end

	task automatic drain();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (result_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			CFG_MOUNT_COUNT:   cfg_mounts = 4'(val);
			CFG_FREE_RATIO:    cfg_ratio = 17'(val);
			CFG_FILES_PER_DIR: cfg_fpd = 16'(val);
			CFG_SUBDIR_COUNT:  cfg_subs = 9'(val);
		endcase
	endtask

	task automatic send_req(place_req_t r, bit chk, place_res_t want);
		place_res_t pred;
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, r.free_mb, r.total_mb, r.mount_sel, r.conn_id};
		s_tuser <= r.mode;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		pred = predict_placement(r);
		result_q.push_back(chk ? want : pred);
	endtask

	initial begin : stimulus
		stim_row_t row;
		for (int m = 0; m < NUM_MOUNTS; m++) begin
			mnt_total[m] = '0;
			mnt_free[m] = '0;
			dir_up[m] = '0;
			dir_lo[m] = '0;
			file_cnt[m] = '0;
		end

		// reset settings: one mount, no fill limit, advance on every file
		t_item(mk_req(MODE_UPDATE, 16'h0, 3'd0, '1, '1), 1'b1, '0);
		t_item(mk_req(MODE_UPDATE, 16'h0, 3'd7, '0, '0), 1'b1, '0);
		t_item(mk_req(MODE_PLACE, 16'hFFFF, 3'd0, '0, '0), 1'b1, '{ST_OK, 3'd0, 8'd0, 8'd1, 1'b1});
		t_item(mk_req(MODE_PLACE, 16'h0000, 3'd0, '0, '0), 1'b1, '{ST_OK, 3'd0, 8'd0, 8'd2, 1'b1});
		// mount count above the table size, ratio above one
		t_cfg(CFG_MOUNT_COUNT, 15);
		t_cfg(CFG_FREE_RATIO, 17'h1FFFF);
		t_item(mk_req(MODE_UPDATE, 16'h0, 3'd1, 32'd100, 32'd99), 1'b1, '0);
		t_item(mk_req(MODE_PLACE, 16'h0001, 3'd0, '0, '0), 1'b0, '0);
		t_item(mk_req(MODE_UPDATE, 16'h0, 3'd0, 32'd10, 32'd0), 1'b1, '0);
		t_item(mk_req(MODE_PLACE, 16'h0008, 3'd0, '0, '0), 1'b0, '0);
		// zero mount count acts as one; every mount in use overfull
		t_cfg(CFG_MOUNT_COUNT, 0);
		t_item(mk_req(MODE_PLACE, 16'hABCD, 3'd0, '0, '0), 1'b1, '{ST_FULL, 3'd0, 8'd0, 8'd0, 1'b0});
		t_cfg(CFG_MOUNT_COUNT, 2);
		t_item(mk_req(MODE_PLACE, 16'h0001, 3'd0, '0, '0), 1'b1, '{ST_FULL, 3'd0, 8'd0, 8'd0, 1'b0});
		// zero files per dir and zero subdirs
		t_cfg(CFG_FREE_RATIO, 0);
		t_cfg(CFG_FILES_PER_DIR, 0);
		t_cfg(CFG_SUBDIR_COUNT, 0);
		t_item(mk_req(MODE_PLACE, 16'h0001, 3'd0, '0, '0), 1'b1, '{ST_OK, 3'd1, 8'd0, 8'd0, 1'b1});
		t_cfg(CFG_SUBDIR_COUNT, 511);
		t_cfg(CFG_FILES_PER_DIR, 3);
		for (int k = 0; k < 3; k++)
			t_item(mk_req(MODE_PLACE, 16'h0000, 3'd0, '0, '0), 1'b0, '0);
		// stored index beyond a lowered subdir count, then upper wrap
		t_cfg(CFG_SUBDIR_COUNT, 2);
		t_cfg(CFG_FILES_PER_DIR, 1);
		for (int k = 0; k < 3; k++)
			t_item(mk_req(MODE_PLACE, 16'h0000, 3'd0, '0, '0), 1'b0, '0);
		t_cfg(CFG_MOUNT_COUNT, 8);
		t_cfg(CFG_FILES_PER_DIR, 65535);
		t_cfg(CFG_FREE_RATIO, 65536);
		t_item(mk_req(MODE_UPDATE, 16'h0, 3'd3, '0, '1), 1'b1, '0);
		t_item(mk_req(MODE_PLACE, 16'h0003, 3'd0, '0, '0), 1'b0, '0);
		t_item(mk_req(MODE_PLACE, 16'hFFFB, 3'd0, '0, '0), 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tab[i]) begin
			row = stim_tab[i];
			if (row.is_cfg)
				write_reg(row.idx, row.val);
			else
				send_req(row.req, row.chk, row.want);
		end

		for (int ph = 0; ph < 6; ph++) begin
			snd_idle = (ph < 2) ? 11 : (ph < 4) ? 71 : 0;
			rcv_idle = (ph < 2) ? 71 : (ph < 4) ? 11 : 0;
			if (ph == 5) begin
				ph_mounts[ph] = $urandom_range(1, NUM_MOUNTS);
				ph_ratio[ph] = $urandom_range(0, 131071);
				ph_fpd[ph] = $urandom_range(1, 6);
				ph_subs[ph] = $urandom_range(1, 8);
			end
			write_reg(CFG_MOUNT_COUNT, ph_mounts[ph]);
			write_reg(CFG_FREE_RATIO, ph_ratio[ph]);
			write_reg(CFG_FILES_PER_DIR, ph_fpd[ph]);
			write_reg(CFG_SUBDIR_COUNT, ph_subs[ph]);
			for (int k = 0; k < RAND_ITEMS; k++) begin
				send_req(rand_item(), 1'b0, '0);
				if (k % 40 == 39)
					drain();
			end
		end

		drain();
		repeat (SETTLE_CYC) @(posedge clk);
		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
